// ===== hdl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES package
// Shared constants, types and byte-, word- and state-level functions of AES.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int ROUND_KEY_WORDS = 60;
    localparam int KEY_ROWS        = ROUND_KEY_WORDS / 4;
    localparam int WORD_IDX_W      = $clog2(ROUND_KEY_WORDS);
    localparam int ROW_IDX_W       = $clog2(KEY_ROWS);

    localparam logic [2:0] CFG_KEY_PART_0    = 3'd0;
    localparam logic [2:0] CFG_KEY_PART_1    = 3'd1;
    localparam logic [2:0] CFG_KEY_PART_2    = 3'd2;
    localparam logic [2:0] CFG_KEY_PART_3    = 3'd3;
    localparam logic [2:0] CFG_KEY_SIZE_MODE = 3'd4;

    localparam logic [1:0] MODE_KEY_128 = 2'd0;
    localparam logic [1:0] MODE_KEY_192 = 2'd1;

    localparam logic       REQ_DECRYPT = 1'b1;
    localparam logic [7:0] RCON_FIRST  = 8'h01;
    localparam logic [7:0] GF_REDUCE   = 8'h1b;
    localparam logic [7:0] AFFINE_C    = 8'h63;
    localparam logic [7:0] AFFINE_INV_C = 8'h05;

    typedef struct packed {
        logic                  en;
        logic [WORD_IDX_W-1:0] idx;
        logic [31:0]           enc;
        logic [31:0]           dec;
    } t_key_wr;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    function automatic logic [7:0] inv_affine_lin(input logic [7:0] v);
        return rotl8(v, 1) ^ rotl8(v, 3) ^ rotl8(v, 6);
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] y);
        logic [7:0] b;
        b = inv_affine_lin(y) ^ AFFINE_INV_C;
        return inv_affine_lin(SBOX[b] ^ AFFINE_C);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] mix_word(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24];
        a1 = w[23:16];
        a2 = w[15:8];
        a3 = w[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    function automatic logic [31:0] inv_mix_word(input logic [31:0] w);
        logic [7:0] a [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [7:0] x2, x4, x8;
        for (int j = 0; j < 4; j++) begin
            a[j]   = w[31-8*j -: 8];
            x2     = xt(a[j]);
            x4     = xt(x2);
            x8     = xt(x4);
            m9[j]  = x8 ^ a[j];
            m11[j] = x8 ^ x2 ^ a[j];
            m13[j] = x8 ^ x4 ^ a[j];
            m14[j] = x8 ^ x4 ^ x2;
        end
        return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
                m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
                m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
                m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
    endfunction

    function automatic logic [3:0] key_nk(input logic [1:0] mode);
        logic [3:0] nk;
        case (mode)
            MODE_KEY_128: nk = 4'd4;
            MODE_KEY_192: nk = 4'd6;
            default:      nk = 4'd8;
        endcase
        return nk;
    endfunction

    function automatic logic [127:0] sub_shift_enc(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(4*c+r) -: 8] = SBOX[s[127-8*(4*((c+r)%4)+r) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] sub_shift_dec(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(4*((c+r)%4)+r) -: 8] = inv_sbox(s[127-8*(4*c+r) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            t[127-32*c -: 32] = inv ? inv_mix_word(s[127-32*c -: 32])
                                    : mix_word(s[127-32*c -: 32]);
        end
        return t;
    endfunction

endpackage

// ===== hdl/aes_key_store.sv =====
// ----------------------------------------------------------------------------
// AES key store
// Encryption and decryption round key memories, written one word at a time
// and read one round key row at a time with a registered output.
// ----------------------------------------------------------------------------
module aes_key_store
    import aes_pkg::*;
(
    input  logic                 i_clk,
    input  t_key_wr              i_wr,
    input  logic                 i_rd_en,
    input  logic                 i_rd_dec,
    input  logic [ROW_IDX_W-1:0] i_rd_row,
    output logic [127:0]         o_rd_key
);

    logic [31:0]  r_enc_mem [KEY_ROWS][4];
    logic [31:0]  r_dec_mem [KEY_ROWS][4];
    logic [127:0] r_rd_key;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_enc_mem[i_wr.idx[WORD_IDX_W-1:2]][i_wr.idx[1:0]] <= i_wr.enc;
            r_dec_mem[i_wr.idx[WORD_IDX_W-1:2]][i_wr.idx[1:0]] <= i_wr.dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_rd_dec) begin
                r_rd_key <= {r_dec_mem[i_rd_row][0], r_dec_mem[i_rd_row][1],
                             r_dec_mem[i_rd_row][2], r_dec_mem[i_rd_row][3]};
            end else begin
                r_rd_key <= {r_enc_mem[i_rd_row][0], r_enc_mem[i_rd_row][1],
                             r_enc_mem[i_rd_row][2], r_enc_mem[i_rd_row][3]};
            end
        end
    end

    assign o_rd_key = r_rd_key;

endmodule

// ===== hdl/aes_key_sched.sv =====
// ----------------------------------------------------------------------------
// AES key schedule
// Expands the cipher key one word per cycle and produces the matching
// equivalent inverse cipher word for the decryption store.
// ----------------------------------------------------------------------------
module aes_key_sched
    import aes_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [255:0]  i_key,
    input  logic [1:0]    i_mode,
    output t_key_wr       o_wr,
    output logic          o_done
);

    logic                  r_busy, n_busy;
    logic [WORD_IDX_W-1:0] r_idx, n_idx;
    logic [2:0]            r_mod, n_mod;
    logic [7:0]            r_rcon, n_rcon;
    logic [31:0]           r_win [8];
    logic [3:0]            nk;
    logic [WORD_IDX_W-1:0] total;
    logic [31:0]           t;
    logic [31:0]           w;
    logic                  last;

    always_comb begin
        nk    = key_nk(i_mode);
        total = WORD_IDX_W'(({2'b00, nk} + 6'd7) << 2);
        t     = r_win[0];
        if (r_idx < WORD_IDX_W'(nk)) begin
            w = i_key[255 - 32*r_idx[2:0] -: 32];
        end else begin
            if (r_mod == 3'd0) begin
                t = sub_word({t[23:0], t[31:24]}) ^ {r_rcon, 24'h000000};
            end else if (nk == 4'd8 && r_mod == 3'd4) begin
                t = sub_word(t);
            end
            w = r_win[3'(nk - 4'd1)] ^ t;
        end
        last   = r_busy && (r_idx == total - WORD_IDX_W'(1));
        n_busy = i_start ? 1'b1 : (last ? 1'b0 : r_busy);
        n_idx  = i_start ? '0 : (r_busy ? r_idx + WORD_IDX_W'(1) : r_idx);
        n_mod  = r_mod;
        n_rcon = r_rcon;
        if (i_start) begin
            n_mod  = 3'd0;
            n_rcon = RCON_FIRST;
        end else if (r_busy) begin
            n_mod = (r_mod == 3'(nk - 4'd1)) ? 3'd0 : r_mod + 3'd1;
            if (r_idx >= WORD_IDX_W'(nk) && r_mod == 3'd0) begin
                n_rcon = xt(r_rcon);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_mod  <= n_mod;
        r_rcon <= n_rcon;
        if (r_busy) begin
            r_win[0] <= w;
            for (int k = 1; k < 8; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    always_comb begin
        o_wr.en  = r_busy;
        o_wr.idx = r_idx;
        o_wr.enc = w;
        o_wr.dec = (r_idx < WORD_IDX_W'(4) || r_idx >= total - WORD_IDX_W'(4))
                   ? w : inv_mix_word(w);
    end

    assign o_done = last;

endmodule

// ===== hdl/aes_block_cipher.sv =====
// ----------------------------------------------------------------------------
// AES block cipher
// AES-128/192/256 in ECB mode with stored round keys for encryption and
// the equivalent inverse cipher.
//
//  Channel | Direction | Handshake              | Payload
//  config  | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//  request | in        | i_in_valid/o_in_stall  | i_req_type, i_block_high/low
//  result  | out       | o_out_valid/i_out_stall | o_result_high/low
//
// After acceptance a block fetches the first round key row, adds it, then runs
// one round per cycle against a round key row read from the key memory.
// The first block after reset or a key write first runs the key schedule,
// one word per cycle, expanding 44, 52 or 60 words.
// A stalled result holds the last round; the next request is taken while
// an earlier result still waits.
// ----------------------------------------------------------------------------
module aes_block_cipher
    import aes_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic         i_req_type,
    input  logic [63:0]  i_block_high,
    input  logic [63:0]  i_block_low,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic [63:0]  o_result_high,
    output logic [63:0]  o_result_low
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXPAND = 5'b00010,
        S_FETCH  = 5'b00100,
        S_ADD0   = 5'b01000,
        S_ROUND  = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [63:0]   r_key [4];
    logic [1:0]    r_mode;
    logic          r_keys_ready;
    logic          r_dec;
    logic [127:0]  r_s;
    logic [3:0]    r_cnt, n_cnt;
    logic          r_out_valid;
    logic [127:0]  r_out;
    logic          in_acc;
    logic          cfg_acc;
    logic          cfg_hit;
    logic          sched_start;
    logic          sched_done;
    t_key_wr       key_wr;
    logic          rd_en;
    logic [3:0]    rd_cnt;
    logic [3:0]    nr;
    logic [ROW_IDX_W-1:0] rd_row;
    logic [127:0]  rd_key;
    logic          last;
    logic          finish;
    logic [127:0]  rnd;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign cfg_hit     = cfg_acc && (i_cfg_index <= CFG_KEY_SIZE_MODE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign nr          = key_nk(r_mode) + 4'd6;
    assign last        = (r_cnt == nr);
    assign finish      = (r_state == S_ROUND) && last && (!r_out_valid || !i_out_stall);
    assign sched_start = in_acc && !r_keys_ready;

    always_comb begin
        rnd = r_dec ? sub_shift_dec(r_s) : sub_shift_enc(r_s);
        if (!last) begin
            rnd = mix_cols(rnd, r_dec);
        end
        rnd = rnd ^ rd_key;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        rd_en   = 1'b0;
        rd_cnt  = 4'd0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = r_keys_ready ? S_FETCH : S_EXPAND;
                end
            end
            S_EXPAND: begin
                if (sched_done) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                rd_en   = 1'b1;
                n_state = S_ADD0;
            end
            S_ADD0: begin
                rd_en   = 1'b1;
                rd_cnt  = 4'd1;
                n_cnt   = 4'd1;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                if (!last) begin
                    rd_en  = 1'b1;
                    rd_cnt = r_cnt + 4'd1;
                    n_cnt  = r_cnt + 4'd1;
                end else if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        rd_row = ROW_IDX_W'(r_dec ? nr - rd_cnt : rd_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_keys_ready <= 1'b0;
            r_out_valid  <= 1'b0;
            r_key[0]     <= '0;
            r_key[1]     <= '0;
            r_key[2]     <= '0;
            r_key[3]     <= '0;
            r_mode       <= MODE_KEY_128;
        end else begin
            r_state <= n_state;
            if (cfg_hit) begin
                r_keys_ready <= 1'b0;
            end else if (sched_done) begin
                r_keys_ready <= 1'b1;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_acc) begin
                case (i_cfg_index)
                    CFG_KEY_PART_0:    r_key[0] <= i_cfg_data;
                    CFG_KEY_PART_1:    r_key[1] <= i_cfg_data;
                    CFG_KEY_PART_2:    r_key[2] <= i_cfg_data;
                    CFG_KEY_PART_3:    r_key[3] <= i_cfg_data;
                    CFG_KEY_SIZE_MODE: r_mode   <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        if (in_acc) begin
            r_dec <= (i_req_type == REQ_DECRYPT);
            r_s   <= {i_block_high, i_block_low};
        end else if (r_state == S_ADD0) begin
            r_s <= r_s ^ rd_key;
        end else if (r_state == S_ROUND && !last) begin
            r_s <= rnd;
        end
        if (finish) begin
            r_out <= rnd;
        end
    end

    aes_key_sched u_sched (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sched_start),
        .i_key   ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_mode  (r_mode),
        .o_wr    (key_wr),
        .o_done  (sched_done)
    );

    aes_key_store u_store (
        .i_clk    (i_clk),
        .i_wr     (key_wr),
        .i_rd_en  (rd_en),
        .i_rd_dec (r_dec),
        .i_rd_row (rd_row),
        .o_rd_key (rd_key)
    );

    assign o_out_valid   = r_out_valid;
    assign o_result_high = r_out[127:64];
    assign o_result_low  = r_out[63:0];

endmodule
